[sv/pmrt_pkg.sv]
package pmrt_pkg;

    // Table geometry
    localparam int RECORD_PAIRS = 64;
    localparam int CAPACITY     = 2 * RECORD_PAIRS;
    localparam int ADDR_W       = $clog2(CAPACITY);
    localparam int CNT_W        = 8;

    // Stored ranges, in units of five
    localparam int LEN_MAX   = 511;
    localparam int DIA_MAX   = 127;
    localparam int LEN_LIMIT = (LEN_MAX + 1) * 5;
    localparam int DIA_LIMIT = (DIA_MAX + 1) * 5;

    // Reciprocal of five, scaled by 2^18
    localparam logic [15:0] RECIP5 = 16'hCCCD;
    localparam int RECIP5_SHIFT = 18;

    typedef enum logic [2:0] {
        CMD_APPEND    = 3'd0,
        CMD_OVERWRITE = 3'd1,
        CMD_READ      = 3'd2,
        CMD_DELETE    = 3'd3,
        CMD_FIND      = 3'd4,
        CMD_CLEAR     = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic [3:0] operation;
        logic [4:0] customer;
        logic [2:0] wood_kind;
        logic [8:0] length;
        logic [6:0] diameter;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef struct packed {
        logic [2:0]  cmd;
        logic [6:0]  index;
        logic [4:0]  customer;
        logic [2:0]  wood_kind;
        logic [3:0]  operation_code;
        logic [15:0] length_in;
        logic [15:0] diameter_in;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        length_clamped;
        logic        diameter_clamped;
        logic [6:0]  found_index;
        logic [4:0]  customer_out;
        logic [2:0]  wood_kind_out;
        logic [3:0]  operation_out;
        logic [11:0] length_out;
        logic [9:0]  diameter_out;
        logic [7:0]  record_count_out;
    } rsp_t;

endpackage

[sv/pmrt_ram.sv]
module pmrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[sv/pmrt_round5.sv]
module pmrt_round5 (
    input  logic [15:0] raw,
    input  logic        is_length,
    output logic [8:0]  quot,
    output logic        clamp
);

    logic [16:0] biased;
    logic [16:0] limit;
    logic [27:0] prod;

    assign biased = {1'b0, raw} + 17'd2;
    assign limit  = is_length ? 17'(pmrt_pkg::LEN_LIMIT) : 17'(pmrt_pkg::DIA_LIMIT);
    assign clamp  = biased >= limit;

    // Only reached below the length limit, so twelve bits suffice
    assign prod = 28'(biased[11:0]) * 28'(pmrt_pkg::RECIP5);

    always_comb
    begin
        if (clamp)
        begin
            quot = is_length ? 9'(pmrt_pkg::LEN_MAX) : 9'(pmrt_pkg::DIA_MAX);
        end
        else
        begin
            quot = prod[pmrt_pkg::RECIP5_SHIFT +: 9];
        end
    end

endmodule

[sv/packed_measurement_record_table_unit.sv]
// Channel  Dir  Handshake             Payload
// req      in   req_valid/req_stall   pmrt_pkg::req_t  (one command)
// rsp      out  rsp_valid/rsp_stall   pmrt_pkg::rsp_t  (one result per command)
//
// Append and overwrite round the length, then the diameter, then write; the shared
// divide-by-five unit is used once for length and once for diameter. A read
// captures one RAM record. Delete shifts later records down; find walks down from
// the last record, each record costing one RAM read and, for delete, one write.
// Reset clears the record count, the state and the result valid flag; the table RAM is not cleared.
// A finished result waits in the output register while the next command is taken.
module packed_measurement_record_table_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  pmrt_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output pmrt_pkg::rsp_t  rsp
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_DECODE   = 12'b0000_0000_0010,
        S_RND_LEN  = 12'b0000_0000_0100,
        S_RND_DIA  = 12'b0000_0000_1000,
        S_WRITE    = 12'b0000_0001_0000,
        S_READ_RD  = 12'b0000_0010_0000,
        S_READ_CAP = 12'b0000_0100_0000,
        S_DEL_RD   = 12'b0000_1000_0000,
        S_DEL_WR   = 12'b0001_0000_0000,
        S_SRCH_RD  = 12'b0010_0000_0000,
        S_SRCH_CMP = 12'b0100_0000_0000,
        S_DONE     = 12'b1000_0000_0000
    } state_t;

    localparam int AW = pmrt_pkg::ADDR_W;
    localparam int CW = pmrt_pkg::CNT_W;

    state_t               state_reg, state_next;
    pmrt_pkg::req_t       req_reg, req_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        ptr_reg, ptr_next;
    logic [8:0]           len_q_reg, len_q_next;
    logic [6:0]           dia_q_reg, dia_q_next;
    pmrt_pkg::rsp_t       res_reg, res_next;
    pmrt_pkg::rsp_t       rsp_reg, rsp_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    pmrt_pkg::rec_t       wr_data;
    logic [AW-1:0]        rd_addr;
    logic [pmrt_pkg::REC_W-1:0] rd_data;
    pmrt_pkg::rec_t       rd_rec;

    logic [15:0]          rnd_raw;
    logic                 rnd_is_len;
    logic [8:0]           rnd_quot;
    logic                 rnd_clamp;

    logic                 idx_ok;
    logic                 more_to_shift;

    function automatic pmrt_pkg::rsp_t fill_record(pmrt_pkg::rsp_t r, pmrt_pkg::rec_t rec);
        pmrt_pkg::rsp_t o;
        o               = r;
        o.customer_out  = rec.customer;
        o.wood_kind_out = rec.wood_kind;
        o.operation_out = rec.operation;
        o.length_out    = 12'({rec.length, 2'b00}) + 12'(rec.length);
        o.diameter_out  = 10'({rec.diameter, 2'b00}) + 10'(rec.diameter);
        return o;
    endfunction

    pmrt_ram #(
        .WIDTH (pmrt_pkg::REC_W),
        .DEPTH (pmrt_pkg::CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pmrt_round5 u_round5 (
        .raw       (rnd_raw),
        .is_length (rnd_is_len),
        .quot      (rnd_quot),
        .clamp     (rnd_clamp)
    );

    assign rd_rec        = pmrt_pkg::rec_t'(rd_data);
    assign idx_ok        = CW'(req_reg.index) < count_reg;
    assign more_to_shift = ((CW+1)'(ptr_reg) + (CW+1)'(1)) < (CW+1)'(count_reg);

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        len_q_next     = len_q_reg;
        dia_q_next     = dia_q_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        wr_en      = 1'b0;
        wr_addr    = AW'(req_reg.index);
        wr_data    = {req_reg.operation_code, req_reg.customer, req_reg.wood_kind,
                      len_q_reg, dia_q_reg};
        rd_addr    = ptr_reg;
        rnd_raw    = req_reg.length_in;
        rnd_is_len = 1'b1;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    res_next   = '0;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (req_reg.cmd)
                    pmrt_pkg::CMD_APPEND:
                    begin
                        if (count_reg >= CW'(pmrt_pkg::CAPACITY))
                        begin
                            res_next.status = pmrt_pkg::ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_RND_LEN;
                        end
                    end
                    pmrt_pkg::CMD_OVERWRITE:
                    begin
                        if (!idx_ok)
                        begin
                            res_next.status = pmrt_pkg::ST_RANGE;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_RND_LEN;
                        end
                    end
                    pmrt_pkg::CMD_READ:
                    begin
                        if (!idx_ok)
                        begin
                            res_next.status = pmrt_pkg::ST_RANGE;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_READ_RD;
                        end
                    end
                    pmrt_pkg::CMD_DELETE:
                    begin
                        if (!idx_ok)
                        begin
                            res_next.status = pmrt_pkg::ST_RANGE;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            ptr_next   = AW'(req_reg.index);
                            state_next = S_DEL_RD;
                        end
                    end
                    pmrt_pkg::CMD_FIND:
                    begin
                        res_next.status = pmrt_pkg::ST_NOT_FOUND;
                        if (count_reg == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ptr_next   = AW'(count_reg - CW'(1));
                            state_next = S_SRCH_RD;
                        end
                    end
                    pmrt_pkg::CMD_CLEAR:
                    begin
                        count_next = '0;
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_RND_LEN:
            begin
                len_q_next              = rnd_quot;
                res_next.length_clamped = rnd_clamp;
                state_next              = S_RND_DIA;
            end
            S_RND_DIA:
            begin
                rnd_raw                   = req_reg.diameter_in;
                rnd_is_len                = 1'b0;
                dia_q_next                = rnd_quot[6:0];
                res_next.diameter_clamped = rnd_clamp;
                state_next                = S_WRITE;
            end
            S_WRITE:
            begin
                wr_en = 1'b1;
                if (req_reg.cmd == pmrt_pkg::CMD_APPEND)
                begin
                    wr_addr              = AW'(count_reg);
                    res_next.found_index = 7'(count_reg);
                    count_next           = count_reg + CW'(1);
                end
                else
                begin
                    res_next.found_index = req_reg.index;
                end
                state_next = S_DONE;
            end
            S_READ_RD:
            begin
                rd_addr    = AW'(req_reg.index);
                state_next = S_READ_CAP;
            end
            S_READ_CAP:
            begin
                res_next             = fill_record(res_reg, rd_rec);
                res_next.found_index = req_reg.index;
                state_next           = S_DONE;
            end
            S_DEL_RD:
            begin
                if (more_to_shift)
                begin
                    rd_addr    = AW'(ptr_reg + AW'(1));
                    state_next = S_DEL_WR;
                end
                else
                begin
                    count_next           = count_reg - CW'(1);
                    res_next.found_index = req_reg.index;
                    state_next           = S_DONE;
                end
            end
            S_DEL_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = ptr_reg;
                wr_data    = rd_rec;
                ptr_next   = ptr_reg + AW'(1);
                state_next = S_DEL_RD;
            end
            S_SRCH_RD:
            begin
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                if (rd_rec.customer == req_reg.customer)
                begin
                    res_next             = fill_record(res_reg, rd_rec);
                    res_next.status      = pmrt_pkg::ST_OK;
                    res_next.found_index = 7'(ptr_reg);
                    state_next           = S_DONE;
                end
                else if (ptr_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ptr_next   = ptr_reg - AW'(1);
                    state_next = S_SRCH_RD;
                end
            end
            S_DONE:
            begin
                // wait for the output register to come free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next                  = res_reg;
                    rsp_next.record_count_out = 8'(count_reg);
                    rsp_valid_next            = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        ptr_reg   <= ptr_next;
        len_q_reg <= len_q_next;
        dia_q_reg <= dia_q_next;
        res_reg   <= res_next;
        rsp_reg   <= rsp_next;
    end

endmodule

[sv/pmrt_checker.sv]
module pmrt_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input pmrt_pkg::rsp_t rsp
);

    // a stalled result transaction holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // the sequencer is busy after every accepted command
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken back to back");

    // a result is issued as the sequencer returns to idle
    a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !req_stall)
        else $error("result issued while still busy");

    // a full table reports its capacity
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == pmrt_pkg::ST_FULL)
            |-> (rsp.record_count_out == 8'(pmrt_pkg::CAPACITY)))
        else $error("full status with table not full");

endmodule

bind packed_measurement_record_table_unit pmrt_checker u_checker (.*);
